/* rtl/sha256_pkg.sv */
package sha256_pkg;

  localparam logic CMD_ABSORB = 1'b0;
  localparam logic CMD_FINISH = 1'b1;

  typedef struct packed {
    logic       command;
    logic [7:0] message_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_number;
    logic        final_word;
  } out_word_t;

  typedef logic [0:7][31:0] hash_t;
  typedef logic [0:15][31:0] window_t;

  typedef struct packed {
    logic       load_byte;
    logic       step;
    logic [7:0] byte_in;
  } sched_ctl_t;

  localparam hash_t INIT_H = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

endpackage

/* rtl/sha256_sched.sv */
module sha256_sched
  import sha256_pkg::*;
(
  input  logic        clk,
  input  sched_ctl_t  ctl,
  output logic [31:0] w
);

  window_t     win_r;
  window_t     win_nxt;
  logic [31:0] w1;
  logic [31:0] w14;
  logic [31:0] s0;
  logic [31:0] s1;
  logic [31:0] w_new;

  // The window doubles as the block buffer: bytes shift in at the low end,
  // so after a full block word 0 holds the first four bytes, big-endian.
  assign w1  = win_r[1];
  assign w14 = win_r[14];
  assign s0  = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ {3'b000, w1[31:3]};
  assign s1  = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^
               {10'b0, w14[31:10]};
  assign w_new = s1 + win_r[9] + s0 + win_r[0];
  assign w = win_r[0];

  always_comb begin
    win_nxt = win_r;
    if (ctl.load_byte) begin
      win_nxt = {win_r[0][23:0], win_r[1:15], ctl.byte_in};
    end else if (ctl.step) begin
      win_nxt = {win_r[1:15], w_new};
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

endmodule

/* rtl/sha256_round.sv */
module sha256_round
  import sha256_pkg::*;
(
  input  hash_t       v,
  input  logic [31:0] w,
  input  logic [31:0] k,
  output hash_t       v_nxt
);

  logic [31:0] a;
  logic [31:0] e;
  logic [31:0] big_s0;
  logic [31:0] big_s1;
  logic [31:0] ch;
  logic [31:0] maj;
  logic [31:0] t1;
  logic [31:0] t2;

  assign a      = v[0];
  assign e      = v[4];
  assign big_s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign big_s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign ch     = (e & v[5]) ^ (~e & v[6]);
  assign maj    = (a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]);
  assign t1     = v[7] + big_s1 + ch + k + w;
  assign t2     = big_s0 + maj;

  assign v_nxt = '{t1 + t2, v[0], v[1], v[2], v[3] + t1, v[4], v[5], v[6]};

endmodule

/* rtl/sha256_stream_hasher.sv */
// SHA-256 hasher for a byte stream.
// The input channel (in_valid, in_stall, in_data) takes one word per item:
// an absorb command carries one message byte, a finish command closes the
// message. The result channel (out_valid, out_stall, out_data) gives the
// eight digest words of a finished message, word 0 first, with final_word
// set on the eighth.
// An absorb that completes a 64-byte block starts a compression, in which
// one shared round unit runs the 64 rounds one per cycle and the fold step
// then adds the result into the hash. A finish feeds the padding and length
// bytes through the same byte path one per cycle, then compresses one or two
// final blocks before the first digest word appears; the words then follow
// in order as each is taken. The block takes no new item while it works or
// while digest words are pending.
// When the receiver stalls, the current digest word holds until it is taken.
// After the last word the block is ready for the next message.
// Reset returns the block to an idle state with the initial hash values.
module sha256_stream_hasher
  import sha256_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PAD  = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_FOLD = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]  state_r;
  logic [2:0]  state_nxt;
  logic [5:0]  round_r;
  logic [5:0]  round_nxt;
  logic [5:0]  fill_r;
  logic [5:0]  fill_nxt;
  logic [60:0] bytes_r;
  logic [60:0] bytes_nxt;
  logic [63:0] len_r;
  logic [63:0] len_nxt;
  logic        fin_r;
  logic        fin_nxt;
  logic        sent80_r;
  logic        sent80_nxt;
  logic        lenph_r;
  logic        lenph_nxt;
  logic [2:0]  idx_r;
  logic [2:0]  idx_nxt;
  hash_t       work_r;
  hash_t       work_nxt;
  hash_t       chain_r;
  hash_t       chain_nxt;

  hash_t       round_out;
  logic [31:0] w;
  sched_ctl_t  sctl;
  logic        take_in;
  logic        len_mode;
  logic [7:0]  pad_byte;

  sha256_sched u_sched (
    .clk (clk),
    .ctl (sctl),
    .w   (w)
  );

  sha256_round u_round (
    .v     (work_r),
    .w     (w),
    .k     (ROUND_K[round_r]),
    .v_nxt (round_out)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign take_in   = in_valid && (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_EMIT);
  assign out_data  = '{digest_word: chain_r[idx_r], word_number: idx_r,
                       final_word: (idx_r == LAST_WORD)};

  assign len_mode = sent80_r && (lenph_r || (fill_r == LEN_START));

  always_comb begin
    if (!sent80_r) begin
      pad_byte = PAD_MARK;
    end else if (len_mode) begin
      pad_byte = len_r[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    round_nxt  = round_r;
    fill_nxt   = fill_r;
    bytes_nxt  = bytes_r;
    len_nxt    = len_r;
    fin_nxt    = fin_r;
    sent80_nxt = sent80_r;
    lenph_nxt  = lenph_r;
    idx_nxt    = idx_r;
    work_nxt   = work_r;
    chain_nxt  = chain_r;
    sctl       = '{load_byte: 1'b0, step: 1'b0, byte_in: in_data.message_byte};

    case (state_r)
      ST_IDLE: begin
        if (take_in) begin
          if (in_data.command == CMD_ABSORB) begin
            sctl.load_byte = 1'b1;
            bytes_nxt = bytes_r + 61'd1;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == LAST_FILL) begin
              state_nxt = ST_COMP;
              round_nxt = '0;
              work_nxt = chain_r;
            end
          end else begin
            fin_nxt = 1'b1;
            sent80_nxt = 1'b0;
            lenph_nxt = 1'b0;
            len_nxt = {bytes_r, 3'b000};
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        sctl.load_byte = 1'b1;
        sctl.byte_in = pad_byte;
        fill_nxt = fill_r + 6'd1;
        if (!sent80_r) begin
          sent80_nxt = 1'b1;
        end else if (len_mode) begin
          lenph_nxt = 1'b1;
          len_nxt = {len_r[55:0], 8'h00};
        end
        if (fill_r == LAST_FILL) begin
          state_nxt = ST_COMP;
          round_nxt = '0;
          work_nxt = chain_r;
        end
      end
      ST_COMP: begin
        sctl.step = 1'b1;
        work_nxt = round_out;
        round_nxt = round_r + 6'd1;
        if (round_r == LAST_ROUND) begin
          state_nxt = ST_FOLD;
        end
      end
      ST_FOLD: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        idx_nxt = '0;
        if (lenph_r) begin
          state_nxt = ST_EMIT;
        end else if (fin_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == LAST_WORD) begin
            chain_nxt = INIT_H;
            bytes_nxt = '0;
            fill_nxt = '0;
            fin_nxt = 1'b0;
            sent80_nxt = 1'b0;
            lenph_nxt = 1'b0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      round_r  <= '0;
      fill_r   <= '0;
      bytes_r  <= '0;
      fin_r    <= 1'b0;
      sent80_r <= 1'b0;
      lenph_r  <= 1'b0;
      idx_r    <= '0;
      chain_r  <= INIT_H;
    end else begin
      state_r  <= state_nxt;
      round_r  <= round_nxt;
      fill_r   <= fill_nxt;
      bytes_r  <= bytes_nxt;
      fin_r    <= fin_nxt;
      sent80_r <= sent80_nxt;
      lenph_r  <= lenph_nxt;
      idx_r    <= idx_nxt;
      chain_r  <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    work_r <= work_nxt;
  end

endmodule
